// ----- hw/rtl/cmis_pkg.sv -----
// Package: shared constants, codes and control structs of the cross mean image sampler.
package cmis_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int COORD_W    = 8;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int SIZE_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

    // Five channel values of at most 255 each sum to at most 1275.
    localparam int SUM_W      = 11;
    // floor(x / 5) == (x * 1639) >> 13 for every x up to 1275.
    localparam int RECIP_W    = 11;
    localparam int RECIP      = 1639;
    localparam int RECIP_SH   = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MODE  = 2'd2;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic MODE_NEAREST = 1'b0;
    localparam logic MODE_CROSS   = 1'b1;

    typedef enum logic [2:0] {
        PT_CENTER = 3'd0,
        PT_UP     = 3'd1,
        PT_DOWN   = 3'd2,
        PT_LEFT   = 3'd3,
        PT_RIGHT  = 3'd4
    } pt_t;

    typedef struct packed {
        logic load_req;
        logic mem_write;
        pt_t  rd_point;
        logic acc_en;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_write;
        logic in_image;
        logic cross_mode;
        logic out_busy;
    } status_t;

endpackage

// ----- hw/rtl/cmis_if.sv -----
// Interfaces: request channel and result channel of the sampler.
interface cmis_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [cmis_pkg::COORD_W-1:0] row;
    logic [cmis_pkg::COORD_W-1:0] col;
    logic [cmis_pkg::CHAN_W-1:0]  in_red;
    logic [cmis_pkg::CHAN_W-1:0]  in_green;
    logic [cmis_pkg::CHAN_W-1:0]  in_blue;

    modport source (
        output valid, req_type, row, col, in_red, in_green, in_blue,
        input  ready
    );
    modport sink (
        input  valid, req_type, row, col, in_red, in_green, in_blue,
        output ready
    );
endinterface

interface cmis_res_if;
    logic                         valid;
    logic                         ready;
    logic [cmis_pkg::CHAN_W-1:0] out_red;
    logic [cmis_pkg::CHAN_W-1:0] out_green;
    logic [cmis_pkg::CHAN_W-1:0] out_blue;
    logic                         outside_image;

    modport source (
        output valid, out_red, out_green, out_blue, outside_image,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, outside_image,
        output ready
    );
endinterface

// ----- hw/rtl/cross_mean_image_sampler.sv -----
// Top level: cross mean image sampler with request, result and configuration ports.
//
// Usage. The req channel carries two kinds of item. A write item (req_type 0)
// stores in_red/in_green/in_blue at row/col of the image memory; it yields no
// result and is dropped when row/col lies outside the configured size. A sample
// item (req_type 1) yields one item on the res channel: the stored pixel in
// nearest mode, or the per-channel floor of the five-point cross mean (centre,
// up, down, left, right, clamped at the image edges) in cross mode. A sample
// outside the configured size returns zero colour with outside_image set.
// Timing. One item is in work at a time; req.ready is high only while idle.
// From the accepting idle state, a write goes through START back to idle; a sample
// ends in DONE as the result register loads, reaching it from START if outside, via
// LAST in nearest mode, or via READ and LAST in cross mode. The single-port image
// memory reads one of the five points per cycle: centre, up, down, left, right.
// Sample results sit in an output register, so the next item is accepted while
// a result still waits; a further result holds its work until res is taken.
// The user writes configuration (cfg_we, cfg_index, cfg_wdata) only while idle; the
// block itself does not enforce it. Reset restores width 256, height 256 and cross
// mode and empties the result register; image contents are undefined until written.
module cross_mean_image_sampler (
    input  logic                              clk,
    input  logic                              rst_n,
    cmis_req_if.sink                          req,
    cmis_res_if.source                        res,
    input  logic                              cfg_we,
    input  logic [cmis_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cmis_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import cmis_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    assign req.ready = in_ready;

    // sequence the reads and writes of each item
    cmis_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // hold the image, sums and result
    cmis_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_req_type (req.req_type),
        .in_row      (req.row),
        .in_col      (req.col),
        .in_pix      ({req.in_red, req.in_green, req.in_blue}),
        .out_ready   (res.ready),
        .out_valid   (res.valid),
        .out_red     (res.out_red),
        .out_green   (res.out_green),
        .out_blue    (res.out_blue),
        .out_outside (res.outside_image),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ----- hw/rtl/cmis_ctrl.sv -----
// Controller: sequences pixel writes and the point reads of one sample.
module cmis_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cmis_pkg::status_t status,
    output cmis_pkg::cmd_t    cmd
);
    import cmis_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_READ  = 5'b00100,
        S_LAST  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    pt_t    pt_reg, pt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pt_reg    <= PT_CENTER;
        end
        else
        begin
            state_reg <= state_next;
            pt_reg    <= pt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        pt_next      = pt_reg;
        in_ready     = 1'b0;
        cmd.load_req  = 1'b0;
        cmd.mem_write = 1'b0;
        cmd.rd_point  = pt_reg;
        cmd.acc_en    = 1'b0;
        cmd.load_out  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_req = in_valid;
                if (in_valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.rd_point = PT_CENTER;
                if (status.is_write)
                begin
                    // drop writes outside the configured size
                    cmd.mem_write = status.in_image;
                    state_next    = S_IDLE;
                end
                else if (!status.in_image)
                begin
                    state_next = S_DONE;
                end
                else if (status.cross_mode)
                begin
                    pt_next    = PT_UP;
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_LAST;
                end
            end
            S_READ:
            begin
                // issue this point, accumulate the previous one
                cmd.acc_en = 1'b1;
                unique case (pt_reg)
                    PT_UP:    pt_next = PT_DOWN;
                    PT_DOWN:  pt_next = PT_LEFT;
                    PT_LEFT:  pt_next = PT_RIGHT;
                    default:  pt_next = PT_CENTER;
                endcase
                if (pt_reg == PT_RIGHT)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                cmd.acc_en = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/cmis_dp.sv -----
// Datapath: configuration, request latch, image memory, sums and output register.
module cmis_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [cmis_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cmis_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                               in_req_type,
    input  logic [cmis_pkg::COORD_W-1:0]      in_row,
    input  logic [cmis_pkg::COORD_W-1:0]      in_col,
    input  logic [cmis_pkg::PIX_W-1:0]        in_pix,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [cmis_pkg::CHAN_W-1:0]       out_red,
    output logic [cmis_pkg::CHAN_W-1:0]       out_green,
    output logic [cmis_pkg::CHAN_W-1:0]       out_blue,
    output logic                               out_outside,
    input  cmis_pkg::cmd_t                     cmd,
    output cmis_pkg::status_t                  status
);
    import cmis_pkg::*;

    logic [SIZE_W-1:0]  width_cfg_reg;
    logic [SIZE_W-1:0]  height_cfg_reg;
    logic               mode_reg;

    logic               type_reg;
    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] col_reg;
    logic [PIX_W-1:0]   pix_reg;

    logic [PIX_W-1:0]   mem [DEPTH];
    logic [PIX_W-1:0]   rd_data_reg;

    logic [SUM_W-1:0]   sum_reg [3];
    logic               out_valid_reg;
    logic [CHAN_W-1:0]  out_chan_reg [3];
    logic               outside_reg;

    logic [SIZE_W-1:0]  w_eff;
    logic [SIZE_W-1:0]  h_eff;
    logic               in_image;
    logic [COORD_W-1:0] up_row;
    logic [COORD_W-1:0] down_row;
    logic [COORD_W-1:0] left_col;
    logic [COORD_W-1:0] right_col;
    logic [COORD_W-1:0] pt_row;
    logic [COORD_W-1:0] pt_col;
    logic [ADDR_W-1:0]  addr;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v, input int lim);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (32'(v) > lim)
            r = SIZE_W'(lim);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [CHAN_W-1:0] div5(input logic [SUM_W-1:0] s);
        logic [SUM_W+RECIP_W-1:0] p;
        p = (SUM_W+RECIP_W)'(s) * (SUM_W+RECIP_W)'(RECIP);
        return p[RECIP_SH +: CHAN_W];
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= SIZE_W'(256);
            height_cfg_reg <= SIZE_W'(256);
            mode_reg       <= MODE_CROSS;
        end
        else if (cfg_we)
        begin
            priority case (cfg_index)
                CFG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_wdata[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT: height_cfg_reg <= cfg_wdata[SIZE_W-1:0];
                CFG_SAMPLE_MODE:  mode_reg       <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // request latch
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            type_reg <= in_req_type;
            row_reg  <= in_row;
            col_reg  <= in_col;
            pix_reg  <= in_pix;
        end
    end

    always_comb
    begin
        w_eff    = eff_size(width_cfg_reg, MAX_WIDTH);
        h_eff    = eff_size(height_cfg_reg, MAX_HEIGHT);
        in_image = (SIZE_W'(row_reg) < h_eff) && (SIZE_W'(col_reg) < w_eff);

        up_row    = (row_reg != '0) ? row_reg - COORD_W'(1) : row_reg;
        down_row  = ((SIZE_W'(row_reg) + SIZE_W'(1)) < h_eff) ? row_reg + COORD_W'(1) : row_reg;
        left_col  = (col_reg != '0) ? col_reg - COORD_W'(1) : col_reg;
        right_col = ((SIZE_W'(col_reg) + SIZE_W'(1)) < w_eff) ? col_reg + COORD_W'(1) : col_reg;

        pt_row = row_reg;
        pt_col = col_reg;
        unique case (cmd.rd_point)
            PT_UP:    pt_row = up_row;
            PT_DOWN:  pt_row = down_row;
            PT_LEFT:  pt_col = left_col;
            PT_RIGHT: pt_col = right_col;
            default:  ;
        endcase
        addr = ADDR_W'(pt_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(pt_col);
    end

    // single-port image memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
            mem[addr] <= pix_reg;
        else
            rd_data_reg <= mem[addr];
    end

    // channel sums, cleared at each accepted item
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (cmd.load_req)
                sum_reg[c] <= '0;
            else if (cmd.acc_en)
                sum_reg[c] <= sum_reg[c] + SUM_W'(rd_data_reg[(2-c)*CHAN_W +: CHAN_W]);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            outside_reg <= !in_image;
            for (int c = 0; c < 3; c++)
            begin
                if (!in_image)
                    out_chan_reg[c] <= '0;
                else if (mode_reg == MODE_CROSS)
                    out_chan_reg[c] <= div5(sum_reg[c]);
                else
                    out_chan_reg[c] <= sum_reg[c][CHAN_W-1:0];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_red     = out_chan_reg[0];
    assign out_green   = out_chan_reg[1];
    assign out_blue    = out_chan_reg[2];
    assign out_outside = outside_reg;

    assign status.is_write   = (type_reg == REQ_WRITE);
    assign status.in_image   = in_image;
    assign status.cross_mode = (mode_reg == MODE_CROSS);
    assign status.out_busy   = out_valid_reg && !out_ready;

endmodule

// ----- tb/tb.sv -----
// Testbench for the cross mean image sampler: stimulus, image shadow and result scoreboard.
`timescale 1ns / 1ps

module tb;
    import cmis_pkg::*;

    // Index past the last register; the block must ignore a write to it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    localparam int CROSS_POINTS   = 5;
    localparam int RANDOM_ITEMS   = 1975;
    localparam int RANDOM_PHASES  = 10;
    // Longest work is a cross sample; leave margin for the output register.
    localparam int DRAIN_CYCLES   = 16;
    // Cycles with no item moving on either channel before the run is called hung.
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic                kind;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   pix;
    } pixel_req_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              outside;
    } color_t;

    // Centre, up, down, left, right store addresses of one sample position.
    typedef logic [CROSS_POINTS-1:0][ADDR_W-1:0] addr5_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    cmis_req_if req_ch ();
    cmis_res_if res_ch ();

    cross_mean_image_sampler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow of the image store and of the registers, updated as items are accepted.
    logic [PIX_W-1:0]  shadow_image [DEPTH];
    bit                pixel_known  [DEPTH];
    logic [SIZE_W-1:0] width_setting  = 9'd256;
    logic [SIZE_W-1:0] height_setting = 9'd256;
    logic              mode_setting   = MODE_CROSS;

    color_t expected_colors [$];

    int unsigned items_sent   = 0;
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;
    // Chance in tenths of starting an idle burst on either side; zero turns idling off.
    int unsigned idle_level   = 0;

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Saturate a size register to 1..limit, as the block does.
    function automatic int unsigned eff_dim(logic [SIZE_W-1:0] v, int unsigned limit);
        if (v == 0)
        begin
            return 1;
        end
        if (v > limit)
        begin
            return limit;
        end
        return 32'(v);
    endfunction

    function automatic logic [ADDR_W-1:0] pix_addr(int unsigned r, int unsigned c);
        return ADDR_W'(r * MAX_WIDTH + c);
    endfunction

    // Neighbours clamp to the configured image, never to the store size.
    function automatic addr5_t cross_addrs(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
        int unsigned w;
        int unsigned h;
        addr5_t pts;
        w = eff_dim(width_setting, MAX_WIDTH);
        h = eff_dim(height_setting, MAX_HEIGHT);
        pts[0] = pix_addr(r, c);
        pts[1] = pix_addr((r > 0) ? r - 1 : 0, c);
        pts[2] = pix_addr((r + 1 < h) ? r + 1 : h - 1, c);
        pts[3] = pix_addr(r, (c > 0) ? c - 1 : 0);
        pts[4] = pix_addr(r, (c + 1 < w) ? c + 1 : w - 1);
        return pts;
    endfunction

    function automatic color_t expected_color(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
        color_t o;
        addr5_t pts;
        int unsigned sum;
        logic [CHAN_W-1:0] mean [3];
        o = '0;
        if (r >= eff_dim(height_setting, MAX_HEIGHT) || c >= eff_dim(width_setting, MAX_WIDTH))
        begin
            o.outside = 1'b1;
            return o;
        end
        pts = cross_addrs(r, c);
        if (mode_setting == MODE_NEAREST)
        begin
            {o.red, o.green, o.blue} = shadow_image[pts[0]];
            return o;
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            sum = 0;
            for (int k = 0; k < CROSS_POINTS; k++)
            begin
                sum += shadow_image[pts[k]][PIX_W-1-CHAN_W*ch -: CHAN_W];
            end
            mean[ch] = CHAN_W'(sum / CROSS_POINTS);
        end
        o.red   = mean[0];
        o.green = mean[1];
        o.blue  = mean[2];
        return o;
    endfunction

    // Apply one accepted item to the shadow: store a pixel or queue a colour.
    function automatic void log_accepted(pixel_req_t it);
        logic [ADDR_W-1:0] a;
        a = pix_addr(it.row, it.col);
        if (it.kind == REQ_SAMPLE)
        begin
            expected_colors.push_back(expected_color(it.row, it.col));
            items_sent++;
        end
        else if (it.row < eff_dim(height_setting, MAX_HEIGHT) &&
                 it.col < eff_dim(width_setting, MAX_WIDTH))
        begin
            shadow_image[a] = it.pix;
            pixel_known[a]  = 1'b1;
            items_sent++;
        end
    endfunction

    function automatic pixel_req_t make_req(logic kind, int unsigned r, int unsigned c,
                                            int unsigned pix);
        pixel_req_t it;
        it.kind = kind;
        it.row  = COORD_W'(r);
        it.col  = COORD_W'(c);
        it.pix  = PIX_W'(pix);
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Drive one item and hold it until the block takes it. Leave valid high
    // afterwards so back-to-back items never drop it within one step.
    task automatic send_item(pixel_req_t it);
        if (idle_level != 0 && $urandom_range(0, 9) < idle_level)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= it.kind;
        req_ch.row      <= it.row;
        req_ch.col      <= it.col;
        {req_ch.in_red, req_ch.in_green, req_ch.in_blue} <= it.pix;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        log_accepted(it);
    endtask

    // Write every point the sample will read that has not been written yet,
    // so no read of an unwritten entry is ever caused.
    task automatic fill_neighbourhood(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
        addr5_t pts;
        int unsigned used;
        pts  = cross_addrs(r, c);
        used = (mode_setting == MODE_CROSS) ? CROSS_POINTS : 1;
        for (int k = 0; k < used; k++)
        begin
            if (!pixel_known[pts[k]])
            begin
                send_item(make_req(REQ_WRITE, pts[k] / MAX_WIDTH, pts[k] % MAX_WIDTH,
                                   $urandom()));
            end
        end
    endtask

    task automatic sample_at(int unsigned r, int unsigned c);
        fill_neighbourhood(COORD_W'(r), COORD_W'(c));
        send_item(make_req(REQ_SAMPLE, r, c, $urandom()));
    endtask

    // Drop valid, wait for every queued colour, then let a trailing write finish.
    task automatic drain_block();
        req_ch.valid <= 1'b0;
        while (expected_colors.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_IMAGE_WIDTH:  width_setting  = value;
            CFG_IMAGE_HEIGHT: height_setting = value;
            CFG_SAMPLE_MODE:  mode_setting   = value[0];
            default: ;
        endcase
    endtask

    task automatic program_image(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h, logic mode);
        drain_block();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_SAMPLE_MODE, {{(CFG_DATA_W-1){1'b0}}, mode});
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic note_failure(string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("%s", msg);
        end
    endtask

    // Stall the result channel in random bursts; hold ready high when idling is off.
    initial
    begin
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_level != 0 && $urandom_range(0, 9) < idle_level)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    // Compare each taken result with the oldest queued colour, field by field.
    always @(posedge clk)
    begin
        color_t seen;
        color_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            seen.red     = res_ch.out_red;
            seen.green   = res_ch.out_green;
            seen.blue    = res_ch.out_blue;
            seen.outside = res_ch.outside_image;
            if (expected_colors.size() == 0)
            begin
                note_failure($sformatf("unexpected result r=%0d g=%0d b=%0d outside=%0d",
                                       seen.red, seen.green, seen.blue, seen.outside));
            end
            else
            begin
                want = expected_colors.pop_front();
                if (seen.red !== want.red || seen.green !== want.green ||
                    seen.blue !== want.blue || seen.outside !== want.outside)
                begin
                    note_failure($sformatf(
                        "color wrong: want r=%0d g=%0d b=%0d outside=%0d, got r=%0d g=%0d b=%0d outside=%0d",
                        want.red, want.green, want.blue, want.outside,
                        seen.red, seen.green, seen.blue, seen.outside));
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings (full size, cross mode): saturated sums at one corner,
    // zero at the other, and a mean that must round down.
    task automatic test_corner_extremes();
        send_item(make_req(REQ_WRITE, 0, 0, 24'hFFFFFF));
        send_item(make_req(REQ_WRITE, 1, 0, 24'hFFFFFF));
        send_item(make_req(REQ_WRITE, 0, 1, 24'hFFFFFF));
        send_item(make_req(REQ_SAMPLE, 0, 0, 24'h000000));
        send_item(make_req(REQ_WRITE, 255, 255, 24'h000000));
        send_item(make_req(REQ_WRITE, 254, 255, 24'h000000));
        send_item(make_req(REQ_WRITE, 255, 254, 24'h000000));
        send_item(make_req(REQ_SAMPLE, 255, 255, 24'hFFFFFF));
        // Sums 511, 512, 513 all floor to 102.
        send_item(make_req(REQ_WRITE, 1, 1, 24'h010203));
        send_item(make_req(REQ_WRITE, 2, 1, 24'h000000));
        send_item(make_req(REQ_WRITE, 1, 2, 24'h000000));
        send_item(make_req(REQ_SAMPLE, 1, 1, 24'h5A5A5A));
    endtask

    // Size saturation, nearest mode, out-of-size writes and samples, and
    // the register index past the list.
    task automatic test_size_registers();
        // Keep a known pixel at (2,0), then try to overwrite it while it lies outside.
        send_item(make_req(REQ_WRITE, 2, 0, 24'h5A3CC3));
        program_image(9'd2, 9'd2, MODE_NEAREST);
        write_reg(CFG_UNUSED_INDEX, 9'h1FF);
        send_item(make_req(REQ_WRITE, 2, 0, 24'hA5C33C));
        send_item(make_req(REQ_SAMPLE, 0, 0, 24'h000000));
        send_item(make_req(REQ_SAMPLE, 1, 1, 24'h000000));
        send_item(make_req(REQ_SAMPLE, 2, 0, 24'h000000));
        send_item(make_req(REQ_SAMPLE, 0, 2, 24'h000000));
        // Width 0 acts as 1, height 511 saturates to the maximum.
        program_image(9'd0, 9'h1FF, MODE_NEAREST);
        send_item(make_req(REQ_SAMPLE, 2, 0, 24'h000000));
        send_item(make_req(REQ_SAMPLE, 0, 1, 24'h000000));
        // Width past the maximum, one row: up and down both clamp to row 0.
        program_image(9'd257, 9'd1, MODE_CROSS);
        sample_at(0, 255);
        send_item(make_req(REQ_SAMPLE, 255, 0, 24'hFFFFFF));
    endtask

    // One random item: mostly well-formed samples over written pixels,
    // the rest out-of-size samples, overwrites and writes anywhere.
    task automatic random_item();
        int unsigned w;
        int unsigned h;
        int unsigned pick;
        w    = eff_dim(width_setting, MAX_WIDTH);
        h    = eff_dim(height_setting, MAX_HEIGHT);
        pick = $urandom_range(0, 99);
        if (pick >= 55 && pick < 70 && (w < MAX_WIDTH || h < MAX_HEIGHT))
        begin
            if (w < MAX_WIDTH && (h == MAX_HEIGHT || $urandom_range(0, 1) == 1))
            begin
                send_item(make_req(REQ_SAMPLE, $urandom_range(0, 255),
                                   $urandom_range(w, 255), $urandom()));
            end
            else
            begin
                send_item(make_req(REQ_SAMPLE, $urandom_range(h, 255),
                                   $urandom_range(0, 255), $urandom()));
            end
        end
        else if (pick < 70)
        begin
            sample_at($urandom_range(0, h - 1), $urandom_range(0, w - 1));
        end
        else if (pick < 88)
        begin
            send_item(make_req(REQ_WRITE, $urandom_range(0, h - 1),
                               $urandom_range(0, w - 1), $urandom()));
        end
        else
        begin
            send_item(make_req(REQ_WRITE, $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom()));
        end
    endtask

    // Random traffic over several settings; extremes first, small images after.
    task automatic test_random_traffic();
        logic [SIZE_W-1:0] w_set;
        logic [SIZE_W-1:0] h_set;
        logic              m_set;
        int unsigned       phase_end;
        bit                paused;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: begin w_set = 9'd256; h_set = 9'd256; m_set = MODE_CROSS;   end
                1: begin w_set = 9'd1;   h_set = 9'd1;   m_set = MODE_CROSS;   end
                2: begin w_set = 9'd0;   h_set = 9'd0;   m_set = MODE_NEAREST; end
                3: begin w_set = 9'h1FF; h_set = 9'd3;   m_set = MODE_CROSS;   end
                4: begin w_set = 9'd3;   h_set = 9'd300; m_set = MODE_NEAREST; end
                default:
                begin
                    w_set = SIZE_W'($urandom_range(1, 16));
                    h_set = SIZE_W'($urandom_range(1, 16));
                    m_set = 1'($urandom_range(0, 1));
                end
            endcase
            // Vary the idling per phase, with none at all in the last one.
            idle_level = (phase == RANDOM_PHASES - 1) ? 0 : $urandom_range(0, 4);
            program_image(w_set, h_set, m_set);
            phase_end = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
            paused    = 1'b0;
            while (items_sent < phase_end)
            begin
                random_item();
                // Hold the sender once mid-phase until every queued colour is back.
                if (phase == 6 && !paused && phase_end - items_sent < RANDOM_ITEMS / 20)
                begin
                    drain_block();
                    paused = 1'b1;
                end
            end
        end
    endtask

    task automatic finish_run();
        idle_level = 0;
        drain_block();
        if (expected_colors.size() != 0)
        begin
            $display("%0d colors never arrived", expected_colors.size());
        end
        if (mismatches == 0 && expected_colors.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_IMAGE_WIDTH;
        cfg_wdata      <= '0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_WRITE;
        req_ch.row      <= '0;
        req_ch.col      <= '0;
        req_ch.in_red   <= '0;
        req_ch.in_green <= '0;
        req_ch.in_blue  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_level = 3;
        test_corner_extremes();
        test_size_registers();
        test_random_traffic();
        finish_run();
    end

endmodule
